/* rtl/kpsd_pkg.sv */
package kpsd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } phase_t;

  localparam logic [3:0] COLS_ALL_HIGH  = 4'hF;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd6;

  localparam logic [3:0] CODE_OK     = 4'd10;
  localparam logic [3:0] CODE_CANCEL = 4'd11;
  localparam logic [3:0] CODE_BACK   = 4'd12;
  localparam logic [3:0] CODE_DOT    = 4'd13;
  localparam logic [3:0] CODE_NONE   = 4'd14;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  row;
    logic [3:0]  captured;
    logic [7:0]  count;
  } scan_state_t;

  typedef struct packed {
    logic        key_valid;
    logic [3:0]  key_code;
    logic [3:0]  row_lines;
  } scan_result_t;

  // column 0 sits on bit 3, column 3 on bit 0
  function automatic logic [1:0] first_low_col(input logic [3:0] cols);
    logic [1:0] col;
    col = 2'd3;
    if (!cols[3]) begin
      col = 2'd0;
    end else if (!cols[2]) begin
      col = 2'd1;
    end else if (!cols[1]) begin
      col = 2'd2;
    end
    return col;
  endfunction

  function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] code;
    case ({row, col})
      4'b00_00: code = 4'd1;
      4'b00_01: code = 4'd2;
      4'b00_10: code = 4'd3;
      4'b00_11: code = CODE_OK;
      4'b01_00: code = 4'd4;
      4'b01_01: code = 4'd5;
      4'b01_10: code = 4'd6;
      4'b01_11: code = CODE_CANCEL;
      4'b10_00: code = 4'd7;
      4'b10_01: code = 4'd8;
      4'b10_10: code = 4'd9;
      4'b10_11: code = CODE_BACK;
      4'b11_00: code = 4'd0;
      4'b11_11: code = CODE_DOT;
      default:  code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

/* rtl/kpsd_step.sv */
module kpsd_step (
  input  kpsd_pkg::scan_state_t  state,
  input  logic [3:0]             cols,
  input  logic [7:0]             debounce_ticks,
  output kpsd_pkg::scan_state_t  state_next,
  output kpsd_pkg::scan_result_t result
);
  import kpsd_pkg::*;

  logic [7:0] count_inc;
  logic [3:0] code;

  assign count_inc = (state.count != COUNT_MAX) ? state.count + 8'd1 : state.count;

  always_comb begin
    state_next = state;
    code       = CODE_NONE;
    case (state.phase)
      PH_DEBOUNCE: begin
        if (cols == state.captured) begin
          state_next.count = count_inc;
          if (count_inc >= debounce_ticks) begin
            code             = key_lookup(state.row, first_low_col(state.captured));
            state_next.phase = PH_PRESSED;
          end
        end else begin
          state_next.phase = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (cols == COLS_ALL_HIGH) begin
          state_next.phase = PH_IDLE;
          state_next.row   = state.row + 2'd1;
        end
      end
      default: begin
        // idle, and the unused phase code
        state_next.captured = cols;
        if (cols != COLS_ALL_HIGH) begin
          state_next.phase = PH_DEBOUNCE;
          state_next.count = '0;
        end else begin
          state_next.phase = PH_IDLE;
          state_next.row   = state.row + 2'd1;
        end
      end
    endcase
  end

  assign result.key_valid = (code != CODE_NONE);
  assign result.key_code  = code;
  assign result.row_lines = ~(4'b0001 << state_next.row);

endmodule

/* rtl/keypad_scan_debounce_core.sv */
// 4x4 matrix keypad scanner with debounce.
// Input channel s_*: one beat per scan tick, carrying the active-low column
// reading taken while the current row is driven low.
// Output channel m_*: exactly one beat per input beat, in order, with the
// key flag, the key code and the row drive to apply for the next tick.
// Config channel cfg_*: the debounce tick count, always ready; write it only
// while no beat is in flight.
// Path: an input beat passes through the input register, then the result register,
// where the receiver can take it. Throughput: one beat per cycle while the receiver
// does not stall, set by the single combinational step between the two registers.
// Reset: scanner idle on row 0, captured columns all high, match count 0,
// debounce tick count 6; no beats held.
// When the receiver stalls the result register holds its beat and the input
// register still takes one more beat; after that s_tready drops until the
// receiver takes the waiting result.
module keypad_scan_debounce_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] col_lines, [7:4] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] key_code, [7:4] row_lines
  output logic       m_tuser,   // [0] key_valid
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import kpsd_pkg::*;

  logic         in_valid;
  logic [3:0]   in_cols;
  logic         out_valid;
  scan_result_t out_result;
  scan_state_t  state;
  scan_state_t  state_next;
  scan_result_t step_result;
  logic [7:0]   debounce_ticks;
  logic         advance;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  kpsd_step u_step (
    .state          (state),
    .cols           (in_cols),
    .debounce_ticks (debounce_ticks),
    .state_next     (state_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase    <= PH_IDLE;
      state.row      <= 2'd0;
      state.captured <= COLS_ALL_HIGH;
      state.count    <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cols <= s_tdata[3:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.row_lines, out_result.key_code};
  assign m_tuser  = out_result.key_valid;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import kpsd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  keypad_scan_debounce_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  typedef struct packed {
    logic [3:0]   cols;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  // scanner model state
  phase_t     scan_phase = PH_IDLE;
  logic [1:0] scan_row = 2'd0;
  logic [3:0] held_cols = COLS_ALL_HIGH;
  logic [7:0] match_cnt = 8'd0;
  logic [7:0] debounce_ticks = DEBOUNCE_RESET;

  logic [3:0] key_map [4][4] = '{
    '{4'd1, 4'd2,      4'd3,      CODE_OK},
    '{4'd4, 4'd5,      4'd6,      CODE_CANCEL},
    '{4'd7, 4'd8,      4'd9,      CODE_BACK},
    '{4'd0, CODE_NONE, CODE_NONE, CODE_DOT}
  };

  // runs with debounce_ticks = 1
  dir_row_t dir_rows [24] = '{
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b1101},
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b1011},
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b0111},
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b1110},
    {4'h7, 1'b1, 1'b0, CODE_NONE,   4'b1110},
    {4'h7, 1'b1, 1'b1, 4'd1,        4'b1110},
    {4'h0, 1'b1, 1'b0, CODE_NONE,   4'b1110},
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b1101},
    {4'hE, 1'b1, 1'b0, CODE_NONE,   4'b1101},
    {4'hE, 1'b1, 1'b1, CODE_CANCEL, 4'b1101},
    {4'hF, 1'b1, 1'b0, CODE_NONE,   4'b1011},
    {4'h0, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'h1, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'hF, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'hB, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'hB, 1'b1, 1'b0, CODE_NONE,   4'b0111},
    {4'hA, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'hF, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'h0, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'h0, 1'b1, 1'b1, 4'd1,        4'b1110},
    {4'hF, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'h9, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'h9, 1'b0, 1'b0, CODE_NONE,   4'b0000},
    {4'hF, 1'b0, 1'b0, CODE_NONE,   4'b0000}
  };

  scan_result_t expected_scans [$];
  int  mismatches = 0;
  int  ticks_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_off_req = 1'b0;

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  function automatic scan_result_t predict_scan(input logic [3:0] cols);
    scan_result_t r;
    bit found;
    r.key_valid = 1'b0;
    r.key_code = CODE_NONE;
    found = 1'b0;
    case (scan_phase)
      PH_DEBOUNCE: begin
        if (cols == held_cols) begin
          if (match_cnt != COUNT_MAX) match_cnt = match_cnt + 8'd1;
          if (match_cnt >= debounce_ticks) begin
            for (int c = 0; c < 4; c++) begin
              if (!found && !held_cols[3 - c]) begin
                found = 1'b1;
                r.key_code = key_map[scan_row][c];
                scan_phase = PH_PRESSED;
              end
            end
            r.key_valid = (r.key_code != CODE_NONE);
          end
        end else begin
          scan_phase = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (cols == COLS_ALL_HIGH) begin
          scan_phase = PH_IDLE;
          scan_row = scan_row + 2'd1;
        end
      end
      default: begin
        held_cols = cols;
        if (cols != COLS_ALL_HIGH) begin
          scan_phase = PH_DEBOUNCE;
          match_cnt = 8'd0;
        end else begin
          scan_phase = PH_IDLE;
          scan_row = scan_row + 2'd1;
        end
      end
    endcase
    r.row_lines = ~(4'b0001 << scan_row);
    return r;
  endfunction

  task automatic send_tick(input logic [3:0] cols, input logic typed = 1'b0,
                           input scan_result_t want = '0);
    int gap;
    scan_result_t r;
    gap = pick_gap();
    r = predict_scan(cols);
    expected_scans.push_back(typed ? want : r);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'h0, cols};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    debounce_ticks = value;
  endtask

  // one key press: idle scans, then either noise only, or a debounce run, bounce or noise, and release
  task automatic press_key();
    logic [3:0] p;
    int n;
    int hold;
    repeat ($urandom_range(0, 3)) send_tick(COLS_ALL_HIGH);
    p = 4'($urandom_range(0, 14));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(0, 15)));
      return;
    end
    n = (debounce_ticks == 0) ? 1 : debounce_ticks;
    if ($urandom_range(0, 4) == 0) begin
      hold = $urandom_range(1, n);
    end else begin
      hold = n + $urandom_range(0, 2);
    end
    send_tick(p);
    repeat (hold) send_tick(p);
    if ($urandom_range(0, 3) == 0) send_tick(p ^ 4'(4'h1 << $urandom_range(0, 3)));
    repeat ($urandom_range(0, 3)) send_tick(4'($urandom_range(0, 14)));
    send_tick(COLS_ALL_HIGH);
  endtask

  // result checker and receiver stalls
  initial begin : rx
    int stall_left;
    int hold_left;
    scan_result_t exp_r;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (expected_scans.size() == 0) begin
          $error("unexpected result beat: %h / %b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          exp_r = expected_scans.pop_front();
          if (m_tuser !== exp_r.key_valid) begin
            $error("key_valid: expected %0d, got %0d", exp_r.key_valid, m_tuser);
            mismatches++;
          end
          if (m_tdata[3:0] !== exp_r.key_code) begin
            $error("key_code: expected %0d, got %0d", exp_r.key_code, m_tdata[3:0]);
            mismatches++;
          end
          if (m_tdata[7:4] !== exp_r.row_lines) begin
            $error("row_lines: expected %b, got %b", exp_r.row_lines, m_tdata[7:4]);
            mismatches++;
          end
        end
      end
      if (hold_off_req) begin
        hold_left = 300;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stim
    logic [7:0] phase_ticks [5];
    int phase_items [5];
    phase_ticks = '{8'd0, 8'd2, 8'd255, 8'd3, 8'd0};
    phase_ticks[4] = 8'($urandom_range(4, 12));
    phase_items = '{120, 120, 150, 120, 120};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_ticks(8'd1);
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].cols, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_ticks(phase_ticks[ph]);
      quiet = (ph == 3);
      ticks_sent = 0;
      if (ph == 1) begin
        quiet = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) send_tick(4'($urandom_range(0, 15)));
        quiet = 1'b0;
      end
      while (ticks_sent < phase_items[ph]) begin
        if (ph == 2 && ticks_sent > 100 && ticks_sent < 110) begin
          wait_idle();
        end
        press_key();
      end
    end
    quiet = 1'b0;

    s_tvalid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
